>>> rtl/per_flow_token_bucket_policer_top_defines.svh
// Assertion macros used by the policer back end (pol_back).
`ifndef PER_FLOW_TOKEN_BUCKET_POLICER_TOP_DEFINES_SVH
`define PER_FLOW_TOKEN_BUCKET_POLICER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define POL_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("policer assertion failed");
`define POL_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("policer assertion failed");
`else
`define POL_ASSERT(name, clk, rst, prop)
`define POL_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

>>> rtl/pol_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pol_pkg;

   localparam int FLOW_CAPACITY = 1024;
   localparam int IDX_W = $clog2(FLOW_CAPACITY);
   localparam int CNT_W = $clog2(FLOW_CAPACITY + 1);

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   localparam logic [1:0] VERDICT_PASS      = 2'd0;
   localparam logic [1:0] VERDICT_DROP      = 2'd1;
   localparam logic [1:0] VERDICT_UNTRACKED = 2'd2;

   localparam logic [1:0] CSR_REFILL_SHIFT = 2'd0;
   localparam logic [1:0] CSR_BUCKET_MAX   = 2'd1;
   localparam logic [1:0] CSR_PACKET_COST  = 2'd2;
   localparam logic [1:0] CSR_SOURCE_MASK  = 2'd3;

   localparam int REQ_DATA_W = 184;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic [5:0]  refill_shift;
      logic [7:0]  bucket_max;
      logic [7:0]  packet_cost;
      logic [31:0] source_mask;
   } cfg_type;

   typedef struct packed {
      logic        untracked;
      logic [63:0] key_high;
      logic [39:0] key_low;
      logic [63:0] now;
   } job_type;

   typedef struct packed {
      logic [63:0] key_high;
      logic [39:0] key_low;
      logic [7:0]  tokens;
      logic [63:0] last_seen;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [1:0] verdict;
      logic       table_full;
      logic [7:0] tokens_left;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DIFF,
      ST_SHIFT,
      ST_UPD,
      ST_INS,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

>>> rtl/pol_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pol_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/pol_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pol_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pol_pkg::cfg_type                    cfg,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [pol_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic                                req_tuser,
   output logic                                     job_valid,
   output pol_pkg::job_type                         job,
   input  wire logic                                job_pop
);
   import pol_pkg::*;

   logic [15:0] ether_type;
   logic [7:0]  ip_protocol;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] udp_sport;
   logic [15:0] udp_dport;
   logic [63:0] arrival_time;
   job_type     new_job;
   logic        push;

   job_type     q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;

   assign ether_type   = req_tdata[15:0];
   assign ip_protocol  = req_tdata[23:16];
   assign src_addr     = req_tdata[55:24];
   assign dst_addr     = req_tdata[87:56];
   assign udp_sport    = req_tdata[103:88];
   assign udp_dport    = req_tdata[119:104];
   assign arrival_time = req_tdata[183:120];

   // classify and build the masked flow key
   always_comb begin
      new_job.untracked = !req_tuser || (ether_type != ETHERTYPE_IPV4)
                          || (ip_protocol != PROTO_UDP);
      new_job.key_high  = {src_addr & cfg.source_mask, dst_addr};
      new_job.key_low   = {ip_protocol, udp_sport, udp_dport};
      new_job.now       = arrival_time;
   end

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign job_valid  = (fill_ff != 2'd0);
   assign job        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ job_pop;
      fill_in   = fill_ff + 2'(push) - 2'(job_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_job;
      end
   end
endmodule
`default_nettype wire

>>> rtl/pol_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "per_flow_token_bucket_policer_top_defines.svh"
module pol_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire pol_pkg::cfg_type               cfg,
   input  wire logic                           job_valid,
   input  wire pol_pkg::job_type               job,
   output logic                                job_pop,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [pol_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import pol_pkg::*;

   state_type   state_ff, state_in;
   job_type     job_ff, job_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [7:0]  tok_ff, tok_in;
   logic [63:0] last_ff, last_in;
   logic [63:0] diff_ff, diff_in;
   logic        sat_ff, sat_in;
   logic [7:0]  earned_ff, earned_in;
   rsp_type     res_ff, res_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   logic        wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type   wr_entry;
   entry_type   rd_entry;
   logic [ENTRY_W-1:0] rd_raw;
   logic [63:0] shifted;
   logic [8:0]  sum;
   logic [7:0]  have;

   pol_ram #(.DEPTH(FLOW_CAPACITY), .WIDTH(ENTRY_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (addr_ff),
      .rd_data (rd_raw)
   );

   assign rd_entry = entry_type'(rd_raw);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      tok_in       = tok_ff;
      last_in      = last_ff;
      diff_in      = diff_ff;
      sat_in       = sat_ff;
      earned_in    = earned_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_in       = out_ff;
      job_pop      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_entry     = '{key_high: job_ff.key_high, key_low: job_ff.key_low,
                       tokens: 8'd0, last_seen: job_ff.now};
      shifted      = diff_ff >> cfg.refill_shift;
      sum          = {1'b0, tok_ff} + {1'b0, earned_ff};
      have         = 8'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               job_in  = job;
               addr_in = '0;
               if (job.untracked) begin
                  res_in   = '{verdict: VERDICT_UNTRACKED, table_full: 1'b0,
                               tokens_left: 8'd0};
                  state_in = ST_OUT;
               end else if (count_ff == '0) begin
                  state_in = ST_INS;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (rd_entry.key_high == job_ff.key_high
                && rd_entry.key_low == job_ff.key_low) begin
               tok_in   = rd_entry.tokens;
               last_in  = rd_entry.last_seen;
               state_in = ST_DIFF;
            end else if (CNT_W'(addr_ff) + 1'b1 == count_ff) begin
               state_in = ST_INS;
            end else begin
               addr_in  = addr_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DIFF: begin
            diff_in  = job_ff.now - last_ff;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            sat_in    = (shifted[63:8] != '0) || (shifted[7:0] >= cfg.bucket_max);
            earned_in = shifted[7:0];
            state_in  = ST_UPD;
         end
         ST_UPD: begin
            if (sat_ff || sum > {1'b0, cfg.bucket_max}) begin
               have = cfg.bucket_max;
            end else begin
               have = sum[7:0];
            end
            if (have < cfg.packet_cost) begin
               res_in = '{verdict: VERDICT_DROP, table_full: 1'b0, tokens_left: have};
            end else begin
               res_in = '{verdict: VERDICT_PASS, table_full: 1'b0,
                          tokens_left: have - cfg.packet_cost};
            end
            wr_en           = 1'b1;
            wr_entry.tokens = res_in.tokens_left;
            state_in        = ST_OUT;
         end
         ST_INS: begin
            if (count_ff == CNT_W'(FLOW_CAPACITY)) begin
               res_in = '{verdict: VERDICT_UNTRACKED, table_full: 1'b1,
                          tokens_left: 8'd0};
            end else begin
               res_in.verdict     = VERDICT_PASS;
               res_in.table_full  = 1'b0;
               res_in.tokens_left = (cfg.bucket_max >= cfg.packet_cost)
                                    ? cfg.bucket_max - cfg.packet_cost : 8'd0;
               wr_en           = 1'b1;
               wr_addr         = count_ff[IDX_W-1:0];
               wr_entry.tokens = res_in.tokens_left;
               count_in        = count_ff + 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      addr_ff   <= addr_in;
      tok_ff    <= tok_in;
      last_ff   <= last_in;
      diff_ff   <= diff_in;
      sat_ff    <= sat_in;
      earned_ff <= earned_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.tokens_left, out_ff.table_full, out_ff.verdict};

   `POL_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(FLOW_CAPACITY))
   `POL_ASSERT(a_scan_in_range, clock, reset,
      (state_ff == ST_CMP) |-> (CNT_W'(addr_ff) < count_ff))
   `POL_ASSERT(a_pop_only_idle, clock, reset, job_pop |-> (state_ff == ST_IDLE))
   `POL_ASSERT(a_full_untracked, clock, reset,
      (rsp_tvalid && out_ff.table_full) |-> (out_ff.verdict == VERDICT_UNTRACKED))
   `POL_ASSERT(a_count_step, clock, reset,
      (count_ff != $past(count_ff)) |-> ($past(state_ff) == ST_INS))
endmodule
`default_nettype wire

>>> rtl/per_flow_token_bucket_policer_top.sv
// Per-flow UDP/IPv4 token bucket policer. Each descriptor on req_ yields one
// verdict on rsp_. Flows are looked up by a linear scan of a 1024-entry flow
// table held in one RAM with a registered read, one stored flow at a time;
// new flows are appended at the fill count. A two-entry queue decouples
// intake from the lookup engine. Write the csr_ registers only while no
// descriptor is in flight.
`timescale 1ns / 1ps
`default_nettype none
module per_flow_token_bucket_policer_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // ether_type, ip_protocol, src_addr, dst_addr, udp_sport, udp_dport, arrival_time
   input  wire logic [pol_pkg::REQ_DATA_W-1:0]   req_tdata,
   // headers_complete
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // verdict, table_full, tokens_left, zero pad
   output logic [pol_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [1:0]                       csr_addr,
   input  wire logic [31:0]                      csr_wdata
);
   import pol_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    job_valid;
   job_type job;
   logic    job_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_REFILL_SHIFT: cfg_in.refill_shift = csr_wdata[5:0];
            CSR_BUCKET_MAX:   cfg_in.bucket_max   = csr_wdata[7:0];
            CSR_PACKET_COST:  cfg_in.packet_cost  = csr_wdata[7:0];
            CSR_SOURCE_MASK:  cfg_in.source_mask  = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{refill_shift: 6'd10, bucket_max: 8'd16, packet_cost: 8'd1,
                     source_mask: 32'hf0ffffff};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pol_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_valid  (job_valid),
      .job        (job),
      .job_pop    (job_pop)
   );

   pol_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_valid  (job_valid),
      .job        (job),
      .job_pop    (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import pol_pkg::*;

   typedef struct {
      logic        complete;
      logic [15:0] ether_type;
      logic [7:0]  proto;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [63:0] arrival;
   } descriptor_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [1:0]            csr_addr = '0;
   logic [31:0]           csr_wdata = '0;

   per_flow_token_bucket_policer_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("timeout at %0t", $time);
      $display("*** FAILED ***");
      $finish;
   end

   // policer state as the block should hold it
   logic [5:0]  m_shift = 6'd10;
   logic [7:0]  m_bmax = 8'd16;
   logic [7:0]  m_cost = 8'd1;
   logic [31:0] m_mask = 32'hf0ffffff;
   logic        flow_valid [FLOW_CAPACITY];
   logic [63:0] flow_khi [FLOW_CAPACITY];
   logic [39:0] flow_klo [FLOW_CAPACITY];
   logic [7:0]  flow_tokens [FLOW_CAPACITY];
   logic [63:0] flow_last [FLOW_CAPACITY];
   int          flows_stored = 0;

   rsp_type verdicts_due [$];
   int errors = 0, n_sent = 0, n_checked = 0, n_drop = 0, n_full = 0, n_untracked = 0;
   bit no_idle = 0;
   logic [63:0] clock_ns = 64'd1000;

   initial begin
      for (int i = 0; i < FLOW_CAPACITY; i++) flow_valid[i] = 1'b0;
   end

   function automatic rsp_type police(descriptor_type d);
      rsp_type r;
      logic [63:0] khi, earned, have;
      logic [39:0] klo;
      int hit, free_slot;
      r = '0;
      hit = -1;
      free_slot = -1;
      if (!d.complete || d.ether_type != ETHERTYPE_IPV4 || d.proto != PROTO_UDP) begin
         r.verdict = VERDICT_UNTRACKED;
         return r;
      end
      khi = {d.src & m_mask, d.dst};
      klo = {d.proto, d.sport, d.dport};
      for (int i = 0; i < FLOW_CAPACITY; i++) begin
         if (flow_valid[i]) begin
            if (hit < 0 && flow_khi[i] == khi && flow_klo[i] == klo) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (hit < 0) begin
         if (free_slot < 0) begin
            r.verdict = VERDICT_UNTRACKED;
            r.table_full = 1'b1;
            return r;
         end
         r.verdict = VERDICT_PASS;
         r.tokens_left = (m_bmax >= m_cost) ? m_bmax - m_cost : 8'd0;
         flow_valid[free_slot] = 1'b1;
         flow_khi[free_slot] = khi;
         flow_klo[free_slot] = klo;
         flow_tokens[free_slot] = r.tokens_left;
         flow_last[free_slot] = d.arrival;
         flows_stored++;
         return r;
      end
      earned = (d.arrival - flow_last[hit]) >> m_shift;
      if (earned >= {56'd0, m_bmax}) have = {56'd0, m_bmax};
      else begin
         have = {56'd0, flow_tokens[hit]} + earned;
         if (have > {56'd0, m_bmax}) have = {56'd0, m_bmax};
      end
      if (have < {56'd0, m_cost}) begin
         r.verdict = VERDICT_DROP;
         r.tokens_left = have[7:0];
      end else begin
         r.verdict = VERDICT_PASS;
         r.tokens_left = have[7:0] - m_cost;
      end
      flow_tokens[hit] = r.tokens_left;
      flow_last[hit] = d.arrival;
      return r;
   endfunction

   // call at a falling edge; returns at a falling edge with valid still high
   task automatic send_descriptor(descriptor_type d);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= d.complete;
      req_tdata <= {d.arrival, d.dport, d.sport, d.dst, d.src, d.proto, d.ether_type};
      do @(posedge clock); while (!req_tready);
      verdicts_due.push_back(police(d));
      n_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_REFILL_SHIFT: m_shift = value[5:0];
         CSR_BUCKET_MAX:   m_bmax = value[7:0];
         CSR_PACKET_COST:  m_cost = value[7:0];
         default:          m_mask = value;
      endcase
      @(negedge clock);
   endtask

   function automatic descriptor_type udp_flow(logic [31:0] src, logic [31:0] dst,
                                               logic [15:0] sport, logic [15:0] dport,
                                               logic [63:0] arrival);
      descriptor_type d;
      d.complete = 1'b1;
      d.ether_type = ETHERTYPE_IPV4;
      d.proto = PROTO_UDP;
      d.src = src;
      d.dst = dst;
      d.sport = sport;
      d.dport = dport;
      d.arrival = arrival;
      return d;
   endfunction

   function automatic descriptor_type noise_descriptor();
      descriptor_type d;
      d.complete = 1'($urandom_range(0, 1));
      d.ether_type = ($urandom_range(0, 1)) ? ETHERTYPE_IPV4 : 16'($urandom);
      d.proto = ($urandom_range(0, 1)) ? PROTO_UDP : 8'($urandom);
      d.src = $urandom;
      d.dst = $urandom;
      d.sport = 16'($urandom);
      d.dport = 16'($urandom);
      d.arrival = {$urandom, $urandom};
      return d;
   endfunction

   // checker: one result per transfer against the oldest expectation
   initial begin
      rsp_type got, want;
      int stall;
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.verdict = rsp_tdata[1:0];
         got.table_full = rsp_tdata[2];
         got.tokens_left = rsp_tdata[10:3];
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            want = verdicts_due.pop_front();
            n_checked++;
            if (want.verdict == VERDICT_DROP) n_drop++;
            if (want.table_full) n_full++;
            if (want.verdict == VERDICT_UNTRACKED) n_untracked++;
            if (got.verdict !== want.verdict)
               $display("%0t: verdict expected %0d actual %0d", $time, want.verdict, got.verdict);
            if (got.table_full !== want.table_full)
               $display("%0t: table_full expected %0d actual %0d", $time,
                        want.table_full, got.table_full);
            if (got.tokens_left !== want.tokens_left)
               $display("%0t: tokens_left expected %0d actual %0d", $time,
                        want.tokens_left, got.tokens_left);
            if (got !== want) errors++;
         end
         @(negedge clock);
      end
   end

   task automatic test_directed();
      descriptor_type d;
      d = udp_flow(32'h0a000001, 32'h0a000002, 16'd1000, 16'd53, 64'd0);
      d.complete = 1'b0;
      send_descriptor(d);
      d = udp_flow(32'h0a000001, 32'h0a000002, 16'd1000, 16'd53, 64'd0);
      d.ether_type = 16'h86dd;
      send_descriptor(d);
      d.ether_type = 16'hffff;
      send_descriptor(d);
      d = udp_flow(32'h0a000001, 32'h0a000002, 16'd1000, 16'd53, 64'd0);
      d.proto = 8'd6;
      send_descriptor(d);
      d.proto = 8'hff;
      send_descriptor(d);
      // new flow, then back-to-back packets draining the bucket
      for (int i = 0; i < 18; i++)
         send_descriptor(udp_flow(32'h0a000001, 32'h0a000002, 16'd1000, 16'd53, 64'(i)));
      // masked bits of the source do not split the flow; refill after a long gap
      send_descriptor(udp_flow(32'h0f000001, 32'h0a000002, 16'd1000, 16'd53, 64'd20000));
      // time going backward wraps to a huge elapsed value
      send_descriptor(udp_flow(32'h0a000001, 32'h0a000002, 16'd1000, 16'd53, 64'd5));
      send_descriptor(udp_flow(32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, '1));
      send_descriptor(udp_flow(32'h0, 32'h0, 16'h0, 16'h0, 64'h0));
      wait_drain();
   endtask

   task automatic test_registers();
      // cost above bucket_max: new flow stored empty but passes
      write_csr(CSR_BUCKET_MAX, 32'd1);
      write_csr(CSR_PACKET_COST, 32'd255);
      write_csr(CSR_REFILL_SHIFT, 32'd0);
      write_csr(CSR_SOURCE_MASK, 32'hffffffff);
      send_descriptor(udp_flow(32'h01020304, 32'h05060708, 16'd7, 16'd9, 64'd100));
      send_descriptor(udp_flow(32'h01020304, 32'h05060708, 16'd7, 16'd9, 64'd200));
      send_descriptor(udp_flow(32'h01020305, 32'h05060708, 16'd7, 16'd9, 64'd200));
      wait_drain();
      write_csr(CSR_BUCKET_MAX, 32'd255);
      write_csr(CSR_PACKET_COST, 32'd1);
      write_csr(CSR_REFILL_SHIFT, 32'd63);
      write_csr(CSR_SOURCE_MASK, 32'h0);
      send_descriptor(udp_flow(32'h11111111, 32'h22222222, 16'd1, 16'd2, 64'd0));
      send_descriptor(udp_flow(32'heeeeeeee, 32'h22222222, 16'd1, 16'd2, 64'h8000000000000000));
      send_descriptor(udp_flow(32'h0, 32'h22222222, 16'd1, 16'd2, 64'h8000000000000001));
      wait_drain();
      // lowered bucket_max caps a stored count on the next packet
      write_csr(CSR_BUCKET_MAX, 32'd3);
      write_csr(CSR_REFILL_SHIFT, 32'd0);
      send_descriptor(udp_flow(32'h11111111, 32'h22222222, 16'd1, 16'd2, 64'h8000000000000001));
      send_descriptor(udp_flow(32'h11111111, 32'h22222222, 16'd1, 16'd2, 64'h8000000000000002));
      wait_drain();
   endtask

   task automatic test_random();
      logic [31:0] pool_src [16], pool_dst [16];
      logic [15:0] pool_sp [16], pool_dp [16];
      descriptor_type d;
      int k;
      for (int phase = 0; phase < 6; phase++) begin
         no_idle = (phase == 2);
         write_csr(CSR_REFILL_SHIFT, (phase == 0) ? 0 : (phase == 5) ? 63 : $urandom_range(0, 20));
         write_csr(CSR_BUCKET_MAX, (phase == 1) ? 255 : (phase == 3) ? 1 : $urandom_range(1, 255));
         write_csr(CSR_PACKET_COST, (phase == 1) ? 255 : (phase == 4) ? 1 : $urandom_range(1, 40));
         write_csr(CSR_SOURCE_MASK, (phase == 0) ? 32'hffffffff : (phase == 3) ? 0 : $urandom);
         for (int i = 0; i < 16; i++) begin
            pool_src[i] = $urandom;
            pool_dst[i] = $urandom;
            pool_sp[i] = 16'($urandom);
            pool_dp[i] = 16'($urandom);
         end
         for (int n = 0; n < 25; n++) begin
            if ($urandom_range(0, 9) < 2) d = noise_descriptor();
            else begin
               k = $urandom_range(0, 15);
               if ($urandom_range(0, 19) == 0) clock_ns = {$urandom, $urandom};
               else clock_ns += 64'($urandom_range(0, 65535)) << $urandom_range(0, 16);
               d = udp_flow(pool_src[k] ^ ($urandom_range(0, 3) == 0 ? ~m_mask : 32'h0),
                            pool_dst[k], pool_sp[k], pool_dp[k], clock_ns);
            end
            send_descriptor(d);
            // hold off once until everything in flight has come back
            if (phase == 1 && n == 12) wait_drain();
         end
         wait_drain();
      end
      no_idle = 0;
   endtask

   task automatic test_table_full();
      int n;
      write_csr(CSR_SOURCE_MASK, 32'hffffffff);
      no_idle = 1;
      n = 0;
      while (flows_stored < FLOW_CAPACITY && n < 4 * FLOW_CAPACITY) begin
         send_descriptor(udp_flow(32'hc0a80000 | n, 32'hdeadbeef, 16'h5a5a, 16'ha5a5, 64'(n)));
         n++;
      end
      no_idle = 0;
      for (int i = 0; i < 3; i++)
         send_descriptor(udp_flow(32'h7f000000 | i, 32'h0badf00d, 16'd1, 16'd1, 64'd0));
      send_descriptor(udp_flow(32'hc0a80000, 32'hdeadbeef, 16'h5a5a, 16'ha5a5, 64'hffff));
      send_descriptor(noise_descriptor());
      wait_drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_registers();
      test_random();
      test_table_full();
      repeat (20) @(posedge clock);
      if (verdicts_due.size() != 0) errors++;
      $display("%0d descriptors sent, %0d verdicts checked", n_sent, n_checked);
      $display("%0d drops, %0d untracked, %0d table-full, %0d flows stored",
               n_drop, n_untracked, n_full, flows_stored);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

>>> files.f
+incdir+rtl
rtl/pol_pkg.sv
rtl/pol_ram.sv
rtl/pol_front.sv
rtl/pol_back.sv
rtl/per_flow_token_bucket_policer_top.sv
bench/testbench.sv
